### hdl/trsp_pkg.sv
// trsp_pkg: shared types and constants for the tagged record stream parser.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package trsp_pkg;

  // Parse phases of the front end
  typedef enum logic [3:0] {
    PH_ID       = 4'd0,
    PH_COUNT    = 4'd1,
    PH_NAMELEN  = 4'd2,
    PH_NAME     = 4'd3,
    PH_TYPE1    = 4'd4,
    PH_TYPE2    = 4'd5,
    PH_FIXED    = 4'd6,
    PH_STRLEN   = 4'd7,
    PH_STRBYTES = 4'd8,
    PH_FINISHED = 4'd9,
    PH_FAILED   = 4'd10
  } phase_t;

  // Result kinds
  localparam logic [2:0] K_ID      = 3'd0;
  localparam logic [2:0] K_COUNT   = 3'd1;
  localparam logic [2:0] K_NAMELEN = 3'd2;
  localparam logic [2:0] K_BYTE    = 3'd3;
  localparam logic [2:0] K_VALUE   = 3'd4;
  localparam logic [2:0] K_DONE    = 3'd5;
  localparam logic [2:0] K_ERROR   = 3'd6;

  // Value types
  localparam logic [1:0] T_NIL    = 2'd0;
  localparam logic [1:0] T_BOOL   = 2'd1;
  localparam logic [1:0] T_NUMBER = 2'd2;
  localparam logic [1:0] T_STRING = 2'd3;

  localparam logic ERR_EARLY_END = 1'b0;
  localparam logic ERR_BAD_TAG   = 1'b1;

  localparam int MAX_RES = 4;

  // One result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [1:0]  vtype;
    logic        is_next_value;
    logic [31:0] record_index;
    logic        error_code;
    logic        last;
  } result_t;

  // Up to four results caused by one byte
  typedef struct packed {
    logic [2:0]  cnt;
    result_t [MAX_RES-1:0] res;
  } group_t;

endpackage

### hdl/trsp_front.sv
// trsp_front: accepts stream bytes, runs the parse state and builds the
// group of results each byte causes. Depends on trsp_pkg.
`timescale 1ns / 1ps
module trsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_data,
  output logic                grp_valid,
  input  logic                grp_ready,
  output trsp_pkg::group_t    grp
);

  trsp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [63:0] shift_r, shift_nxt;
  logic [31:0] rec_exp_r, rec_exp_nxt;
  logic [31:0] rec_done_r, rec_done_nxt;
  logic [1:0]  tag1_r, tag1_nxt, tag2_r, tag2_nxt;
  logic        bad1_r, bad1_nxt, bad2_r, bad2_nxt;
  logic        slot_r, slot_nxt;
  logic        need8_r, need8_nxt;

  logic        fire;
  trsp_pkg::group_t g;

  assign byte_ready = grp_ready;
  assign fire       = byte_valid && byte_ready;
  assign grp_valid  = byte_valid && (g.cnt != 3'd0);
  assign grp        = g;

  // Parse step for one byte
  always_comb begin
    logic        word_done;
    logic [31:0] word;
    logic [63:0] sh;
    logic [31:0] bc;
    logic        fin;
    logic        go;
    logic [1:0]  t;
    logic        bad;
    logic [31:0] rd;
    int          i;
    trsp_pkg::result_t r;

    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    shift_nxt    = shift_r;
    rec_exp_nxt  = rec_exp_r;
    rec_done_nxt = rec_done_r;
    tag1_nxt     = tag1_r;
    tag2_nxt     = tag2_r;
    bad1_nxt     = bad1_r;
    bad2_nxt     = bad2_r;
    slot_nxt     = slot_r;
    need8_nxt    = need8_r;
    g            = '0;
    word_done    = 1'b0;
    fin          = 1'b0;
    go           = 1'b0;
    t            = '0;
    bad          = 1'b0;
    rd           = rec_done_r;
    r            = '0;

    sh = {shift_r[55:0], data_byte};
    bc = cnt_r + 32'd1;
    word = sh[31:0];
    case (phase_r)
      trsp_pkg::PH_ID, trsp_pkg::PH_COUNT, trsp_pkg::PH_NAMELEN,
      trsp_pkg::PH_TYPE1, trsp_pkg::PH_TYPE2, trsp_pkg::PH_STRLEN: begin
        shift_nxt = sh;
        cnt_nxt   = bc;
        word_done = (bc >= 32'd4);
      end
      trsp_pkg::PH_FIXED: begin
        shift_nxt = sh;
        cnt_nxt   = bc;
        word_done = (bc >= (need8_r ? 32'd8 : 32'd4));
      end
      default: ;
    endcase

    // Results carry record_index of the current record
    r.record_index = rec_done_r;

    case (phase_r)
      trsp_pkg::PH_ID: if (word_done) begin
        r.kind = trsp_pkg::K_ID; r.payload = {32'd0, word};
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
        phase_nxt = trsp_pkg::PH_COUNT; cnt_nxt = '0; shift_nxt = '0;
      end
      trsp_pkg::PH_COUNT: if (word_done) begin
        r.kind = trsp_pkg::K_COUNT; r.payload = {32'd0, word};
        r.record_index = '0;
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
        rec_exp_nxt = word; rec_done_nxt = '0; rd = '0;
        cnt_nxt = '0; shift_nxt = '0;
        if (word == 32'd0) begin
          r.kind = trsp_pkg::K_DONE; r.payload = '0;
          g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
          phase_nxt = trsp_pkg::PH_FINISHED;
        end else phase_nxt = trsp_pkg::PH_NAMELEN;
      end
      trsp_pkg::PH_NAMELEN: if (word_done) begin
        r.kind = trsp_pkg::K_NAMELEN; r.payload = {32'd0, word};
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
        shift_nxt = '0; cnt_nxt = word;
        phase_nxt = (word == 32'd0) ? trsp_pkg::PH_TYPE1 : trsp_pkg::PH_NAME;
      end
      trsp_pkg::PH_NAME: begin
        r.kind = trsp_pkg::K_BYTE; r.payload = {56'd0, data_byte};
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
        cnt_nxt = cnt_r - 32'd1;
        if (cnt_nxt == 32'd0) begin
          phase_nxt = trsp_pkg::PH_TYPE1; shift_nxt = '0;
        end
      end
      trsp_pkg::PH_TYPE1: if (word_done) begin
        tag1_nxt = word[1:0]; bad1_nxt = (word > 32'd3);
        phase_nxt = trsp_pkg::PH_TYPE2; cnt_nxt = '0; shift_nxt = '0;
      end
      trsp_pkg::PH_TYPE2: if (word_done) begin
        tag2_nxt = word[1:0]; bad2_nxt = (word > 32'd3);
        slot_nxt = 1'b0; go = 1'b1;
      end
      trsp_pkg::PH_FIXED: if (word_done) begin
        r.kind = trsp_pkg::K_VALUE;
        r.payload = need8_r ? sh : {32'd0, word};
        r.vtype = slot_r ? tag2_r : tag1_r;
        r.is_next_value = slot_r;
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
        go = 1'b1; fin = 1'b1;
      end
      trsp_pkg::PH_STRLEN: if (word_done) begin
        r.kind = trsp_pkg::K_VALUE; r.payload = {32'd0, word};
        r.vtype = trsp_pkg::T_STRING; r.is_next_value = slot_r;
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
        if (word == 32'd0) begin
          go = 1'b1; fin = 1'b1;
        end else begin
          shift_nxt = '0; cnt_nxt = word; phase_nxt = trsp_pkg::PH_STRBYTES;
        end
      end
      trsp_pkg::PH_STRBYTES: begin
        r.kind = trsp_pkg::K_BYTE; r.payload = {56'd0, data_byte};
        r.vtype = trsp_pkg::T_STRING; r.is_next_value = slot_r;
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
        cnt_nxt = cnt_r - 32'd1;
        if (cnt_nxt == 32'd0) begin
          go = 1'b1; fin = 1'b1;
        end
      end
      default: ;
    endcase

    // Slot walk: at most two slots, so bounded to three passes
    for (i = 0; i < 3; i++) begin
      if (go) begin
        if (fin && slot_nxt) begin
          rd = rec_done_r + 32'd1;
          rec_done_nxt = rd;
          cnt_nxt = '0; shift_nxt = '0;
          go = 1'b0;
          if (rd == rec_exp_r) begin
            r = '0; r.kind = trsp_pkg::K_DONE; r.record_index = rd;
            g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
            phase_nxt = trsp_pkg::PH_FINISHED;
          end else phase_nxt = trsp_pkg::PH_NAMELEN;
        end else begin
          if (fin) slot_nxt = 1'b1;
          t   = slot_nxt ? tag2_nxt : tag1_nxt;
          bad = slot_nxt ? bad2_nxt : bad1_nxt;
          cnt_nxt = '0; shift_nxt = '0;
          fin = 1'b0;
          if (bad) begin
            r = '0; r.kind = trsp_pkg::K_ERROR; r.error_code = trsp_pkg::ERR_BAD_TAG;
            r.record_index = rd;
            g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
            phase_nxt = trsp_pkg::PH_FAILED; go = 1'b0;
          end else if (t == trsp_pkg::T_NIL) begin
            r = '0; r.kind = trsp_pkg::K_VALUE; r.is_next_value = slot_nxt;
            r.record_index = rd;
            g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
            fin = 1'b1;
          end else if (t == trsp_pkg::T_STRING) begin
            phase_nxt = trsp_pkg::PH_STRLEN; go = 1'b0;
          end else begin
            phase_nxt = trsp_pkg::PH_FIXED; go = 1'b0;
            need8_nxt = (t == trsp_pkg::T_NUMBER);
          end
        end
      end
    end

    // End flag: early-end error unless finished or failed, then back to the start
    if (end_of_data) begin
      if (phase_nxt != trsp_pkg::PH_FINISHED && phase_nxt != trsp_pkg::PH_FAILED) begin
        r = '0; r.kind = trsp_pkg::K_ERROR; r.error_code = trsp_pkg::ERR_EARLY_END;
        r.record_index = rec_done_nxt;
        g.res[g.cnt[1:0]] = r; g.cnt = g.cnt + 3'd1;
      end
      phase_nxt = trsp_pkg::PH_ID; cnt_nxt = '0; shift_nxt = '0;
      rec_exp_nxt = '0; rec_done_nxt = '0; tag1_nxt = '0; tag2_nxt = '0;
      bad1_nxt = 1'b0; bad2_nxt = 1'b0; slot_nxt = 1'b0; need8_nxt = 1'b0;
    end

    if (g.cnt != 3'd0) g.res[g.cnt[1:0] - 2'd1].last = 1'b1;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= trsp_pkg::PH_ID;
      cnt_r <= '0; shift_r <= '0; rec_exp_r <= '0; rec_done_r <= '0;
      tag1_r <= '0; tag2_r <= '0; bad1_r <= 1'b0; bad2_r <= 1'b0;
      slot_r <= 1'b0; need8_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt; shift_r <= shift_nxt;
      rec_exp_r <= rec_exp_nxt; rec_done_r <= rec_done_nxt;
      tag1_r <= tag1_nxt; tag2_r <= tag2_nxt;
      bad1_r <= bad1_nxt; bad2_r <= bad2_nxt;
      slot_r <= slot_nxt; need8_r <= need8_nxt;
    end
  end

endmodule

### hdl/trsp_queue.sv
// trsp_queue: two-entry queue of result groups between front and back.
// Depends on trsp_pkg.
`timescale 1ns / 1ps
module trsp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  trsp_pkg::group_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output trsp_pkg::group_t rd_data
);

  trsp_pkg::group_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] fill_r;
  logic wr, rd;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### hdl/trsp_back.sv
// trsp_back: unpacks queued result groups into single output transactions.
// Depends on trsp_pkg.
`timescale 1ns / 1ps
module trsp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               grp_valid,
  output logic               grp_ready,
  input  trsp_pkg::group_t   grp,
  output logic               res_valid,
  input  logic               res_ready,
  output trsp_pkg::result_t  res
);

  logic [1:0] idx_r;
  logic       take;

  assign res_valid = grp_valid;
  assign res       = grp.res[idx_r];
  assign take      = res_valid && res_ready;
  assign grp_ready = take && ({1'b0, idx_r} == grp.cnt - 3'd1);

  // Walk through the group
  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (take) idx_r <= grp_ready ? 2'd0 : idx_r + 2'd1;
  end

endmodule

### hdl/tagged_record_stream_parser_top.sv
// tagged_record_stream_parser_top: top level of the record stream parser.
// Depends on trsp_pkg, trsp_front, trsp_queue, trsp_back.
`timescale 1ns / 1ps
// Takes one stream byte per cycle while the two-group result queue has room;
// a byte that causes N results (up to four) needs N transactions at the
// result port, so the sustained input rate is one byte a cycle only for bytes
// with at most one result while out_tready stays high, set by the single-result output port.
module tagged_record_stream_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // data_byte
  input  logic          in_tlast,   // end_of_data
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [103:0]  out_tdata,  // payload[63:0], record_index[95:64], error_code[96]
  output logic [5:0]    out_tuser,  // kind[2:0], vtype[4:3], is_next_value[5]
  output logic          out_tlast   // last
);

  logic             f_valid, f_ready, q_valid, q_ready;
  trsp_pkg::group_t f_grp, q_grp;
  trsp_pkg::result_t res;
  logic             fr_ready;

  // Bytes with no result pass straight through once accepted
  trsp_front u_front (
    .clk, .rst_n,
    .byte_valid(in_tvalid), .byte_ready(fr_ready),
    .data_byte(in_tdata), .end_of_data(in_tlast),
    .grp_valid(f_valid), .grp_ready(f_ready), .grp(f_grp)
  );
  assign in_tready = fr_ready;

  trsp_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_grp),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_grp)
  );

  trsp_back u_back (
    .clk, .rst_n,
    .grp_valid(q_valid), .grp_ready(q_ready), .grp(q_grp),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {7'd0, res.error_code, res.record_index, res.payload};
  assign out_tuser = {res.is_next_value, res.vtype, res.kind};
  assign out_tlast = res.last;

endmodule

### hdl/trsp_checker.sv
// trsp_checker: port-level checks on the parser, bound to the top level.
// Depends on trsp_pkg for the result kinds and on the top level's ports.
`timescale 1ns / 1ps
module trsp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic [5:0]   out_tuser
);

  // Held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Kind never exceeds error
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:0] <= trsp_pkg::K_ERROR)
    else $error("bad kind");

  // Error code only on error results
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[96] |-> out_tuser[2:0] == trsp_pkg::K_ERROR)
    else $error("error code on non-error");

  // Done and error carry zero payload
  a_pay: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:0] == trsp_pkg::K_DONE || out_tuser[2:0] == trsp_pkg::K_ERROR)
      |-> out_tdata[63:0] == 64'd0)
    else $error("nonzero payload on done or error");

endmodule

bind tagged_record_stream_parser_top trsp_checker u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

### bench/tagged_record_stream_parser_top_tb.sv
// Testbench for tagged_record_stream_parser_top: directed and random record streams,
// with a behavioral predictor, in-order result checking and random stalls on both sides.
// Depends on trsp_pkg and the RTL of the parser.
`timescale 1ns / 1ps
module tagged_record_stream_parser_top_tb;

  localparam int LIMIT    = 20000;
  localparam int HOLD_LEN = 60;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [7:0]    in_tdata = '0;
  logic          in_tlast = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [103:0]  out_tdata;
  logic [5:0]    out_tuser;
  logic          out_tlast;

  tagged_record_stream_parser_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  // Predictor state
  trsp_pkg::phase_t ph;
  int unsigned fbytes;
  logic [63:0] fshift;
  logic [31:0] rec_total, rec_idx;
  logic [1:0]  tag0, tag1;
  logic        bad0, bad1, slot;
  int unsigned fixed_len;

  trsp_pkg::result_t pending[$];   // expected parser results, oldest first
  trsp_pkg::result_t grp[$];
  int          errors = 0;
  int          idle_pct_in = 0, idle_pct_out = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_cycles = 0;
  int          quiet = 0;

  // Byte lists built by the stream generators
  logic [7:0]  sbytes[$];

  function automatic void parser_clear();
    ph = trsp_pkg::PH_ID; fbytes = 0; fshift = '0; rec_total = '0; rec_idx = '0;
    tag0 = trsp_pkg::T_NIL; tag1 = trsp_pkg::T_NIL; bad0 = 1'b0; bad1 = 1'b0;
    slot = 1'b0; fixed_len = 4;
  endfunction

  function automatic void put(logic [2:0] k, logic [63:0] p, logic [1:0] vt,
                              logic s, logic e);
    trsp_pkg::result_t r;
    r.kind = k; r.payload = p; r.vtype = vt; r.is_next_value = s;
    r.record_index = rec_idx; r.error_code = e; r.last = 1'b0;
    grp.insert(grp.size(), r);
  endfunction

  // Walks the value slots after a slot has ended or tags are in
  function automatic void advance_slots(logic ended);
    logic [1:0] t;
    logic b;
    forever begin
      if (ended) begin
        if (!slot) slot = 1'b1;
        else begin
          rec_idx++;
          if (rec_idx == rec_total) begin
            put(trsp_pkg::K_DONE, 64'd0, trsp_pkg::T_NIL, 1'b0, 1'b0);
            ph = trsp_pkg::PH_FINISHED;
          end else ph = trsp_pkg::PH_NAMELEN;
          fbytes = 0; fshift = '0;
          return;
        end
      end
      t = slot ? tag1 : tag0;
      b = slot ? bad1 : bad0;
      fbytes = 0; fshift = '0;
      if (b) begin
        ph = trsp_pkg::PH_FAILED;
        put(trsp_pkg::K_ERROR, 64'd0, trsp_pkg::T_NIL, 1'b0, trsp_pkg::ERR_BAD_TAG);
        return;
      end
      if (t == trsp_pkg::T_NIL) begin
        put(trsp_pkg::K_VALUE, 64'd0, trsp_pkg::T_NIL, slot, 1'b0);
        ended = 1'b1;
        continue;
      end
      if (t == trsp_pkg::T_STRING) ph = trsp_pkg::PH_STRLEN;
      else begin
        ph = trsp_pkg::PH_FIXED; fixed_len = (t == trsp_pkg::T_BOOL) ? 4 : 8;
      end
      return;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    logic wd;
    logic [31:0] w;
    wd = 1'b0; w = '0;
    grp.delete();
    if (ph inside {trsp_pkg::PH_ID, trsp_pkg::PH_COUNT, trsp_pkg::PH_NAMELEN,
                   trsp_pkg::PH_TYPE1, trsp_pkg::PH_TYPE2, trsp_pkg::PH_STRLEN,
                   trsp_pkg::PH_FIXED}) begin
      fshift = {fshift[55:0], b};
      fbytes++;
      if (fbytes >= ((ph == trsp_pkg::PH_FIXED) ? fixed_len : 4)) begin
        wd = 1'b1; w = fshift[31:0];
      end
    end
    case (ph)
      trsp_pkg::PH_ID: if (wd) begin
        put(trsp_pkg::K_ID, {32'd0, w}, trsp_pkg::T_NIL, 1'b0, 1'b0);
        ph = trsp_pkg::PH_COUNT; fbytes = 0; fshift = '0;
      end
      trsp_pkg::PH_COUNT: if (wd) begin
        put(trsp_pkg::K_COUNT, {32'd0, w}, trsp_pkg::T_NIL, 1'b0, 1'b0);
        rec_total = w; rec_idx = '0; fbytes = 0; fshift = '0;
        if (w == 0) begin
          put(trsp_pkg::K_DONE, 64'd0, trsp_pkg::T_NIL, 1'b0, 1'b0);
          ph = trsp_pkg::PH_FINISHED;
        end else ph = trsp_pkg::PH_NAMELEN;
      end
      trsp_pkg::PH_NAMELEN: if (wd) begin
        put(trsp_pkg::K_NAMELEN, {32'd0, w}, trsp_pkg::T_NIL, 1'b0, 1'b0);
        fshift = '0; fbytes = w;
        ph = (w == 0) ? trsp_pkg::PH_TYPE1 : trsp_pkg::PH_NAME;
      end
      trsp_pkg::PH_NAME: begin
        put(trsp_pkg::K_BYTE, {56'd0, b}, trsp_pkg::T_NIL, 1'b0, 1'b0);
        fbytes--;
        if (fbytes == 0) begin
          ph = trsp_pkg::PH_TYPE1; fshift = '0;
        end
      end
      trsp_pkg::PH_TYPE1: if (wd) begin
        tag0 = w[1:0]; bad0 = (w > 3); ph = trsp_pkg::PH_TYPE2; fbytes = 0; fshift = '0;
      end
      trsp_pkg::PH_TYPE2: if (wd) begin
        tag1 = w[1:0]; bad1 = (w > 3); slot = 1'b0; advance_slots(1'b0);
      end
      trsp_pkg::PH_FIXED: if (wd) begin
        put(trsp_pkg::K_VALUE, (fixed_len == 4) ? {32'd0, w} : fshift,
            slot ? tag1 : tag0, slot, 1'b0);
        advance_slots(1'b1);
      end
      trsp_pkg::PH_STRLEN: if (wd) begin
        put(trsp_pkg::K_VALUE, {32'd0, w}, trsp_pkg::T_STRING, slot, 1'b0);
        if (w == 0) advance_slots(1'b1);
        else begin
          fshift = '0; fbytes = w; ph = trsp_pkg::PH_STRBYTES;
        end
      end
      trsp_pkg::PH_STRBYTES: begin
        put(trsp_pkg::K_BYTE, {56'd0, b}, trsp_pkg::T_STRING, slot, 1'b0);
        fbytes--;
        if (fbytes == 0) advance_slots(1'b1);
      end
      default: ;
    endcase
    if (fin) begin
      if (ph != trsp_pkg::PH_FINISHED && ph != trsp_pkg::PH_FAILED)
        put(trsp_pkg::K_ERROR, 64'd0, trsp_pkg::T_NIL, 1'b0, trsp_pkg::ERR_EARLY_END);
      parser_clear();
    end
    if (grp.size() > 0) grp[grp.size()-1].last = 1'b1;
    foreach (grp[i]) pending.insert(pending.size(), grp[i]);
  endfunction

  // Sends one byte; valid stays high across back-to-back transactions
  task automatic send_byte(logic [7:0] b, logic fin);
    while ($urandom_range(99) < idle_pct_in) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= b; in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(b, fin);
  endtask

  task automatic send_stream();
    foreach (sbytes[i]) send_byte(sbytes[i], i == sbytes.size() - 1);
    in_tvalid <= 1'b0;
    sbytes.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    sbytes.insert(sbytes.size(), b);
  endfunction

  function automatic void add_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
  endfunction

  function automatic void add_value(logic [1:0] tag);
    int n;
    case (tag)
      trsp_pkg::T_BOOL: add_word($urandom);
      trsp_pkg::T_NUMBER: begin
        add_word($urandom); add_word($urandom);
      end
      trsp_pkg::T_STRING: begin
        n = $urandom_range(3);
        add_word(32'(n));
        repeat (n) add_byte(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  // Well-formed stream with random content
  function automatic void build_stream(int nrec);
    logic [1:0] t0, t1;
    int n;
    add_word($urandom);
    add_word(32'(nrec));
    repeat (nrec) begin
      n = $urandom_range(3);
      add_word(32'(n));
      repeat (n) add_byte(8'($urandom));
      t0 = 2'($urandom_range(3)); t1 = 2'($urandom_range(3));
      add_word({30'd0, t0}); add_word({30'd0, t1});
      add_value(t0); add_value(t1);
    end
  endfunction

  task automatic wait_drained();
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    trsp_pkg::result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[2:0]; got.vtype = out_tuser[4:3];
      got.is_next_value = out_tuser[5]; got.payload = out_tdata[63:0];
      got.record_index = out_tdata[95:64]; got.error_code = out_tdata[96];
      got.last = out_tlast;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
        errors++;
      end else begin
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_r, got);
          errors++;
        end
      end
    end
  end

  // Receiver: random stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_cycles <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(99) >= idle_pct_out);
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_header_and_zero_count();
    add_word(32'hFFFF_FFFF); add_word(32'd0); add_byte(8'hA5);
    send_stream();
    add_word(32'h0000_0000); add_word(32'hFFFF_FFFF);  // huge count, early end
    send_stream();
  endtask

  task automatic test_all_types();
    add_word(32'h1234_5678); add_word(32'd2);
    // nil then number, name with extreme bytes
    add_word(32'd2); add_byte(8'h00); add_byte(8'hFF);
    add_word({30'd0, trsp_pkg::T_NIL}); add_word({30'd0, trsp_pkg::T_NUMBER});
    add_word(32'hFFFF_FFFF); add_word(32'hFFFF_FFFF);
    // empty name, string then bool
    add_word(32'd0);
    add_word({30'd0, trsp_pkg::T_STRING}); add_word({30'd0, trsp_pkg::T_BOOL});
    add_value(trsp_pkg::T_STRING); add_value(trsp_pkg::T_BOOL);
    send_stream();
  endtask

  task automatic test_bad_tags_and_early_end();
    add_word(32'd1); add_word(32'd1); add_word(32'd0); add_word(32'h8000_0000);
    add_word(32'd0);
    add_byte(8'h11);
    send_stream();
    add_word(32'd1); add_word(32'd1); add_word(32'd0); add_word({30'd0, trsp_pkg::T_BOOL});
    add_word(32'd4);
    add_word(32'hDEAD_BEEF); add_byte(8'h22);
    send_stream();
    add_word(32'd7); add_word(32'd2); add_word(32'd3); add_byte(8'h41);
    send_stream();
    add_byte(8'h00);   // single-byte stream
    send_stream();
  endtask

  task automatic test_random_streams(int nbytes);
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      build_stream($urandom_range(1, 2));
      if ($urandom_range(9) == 0) begin
        // broken: truncate or corrupt a byte
        if ($urandom_range(1)) sbytes = sbytes[0:$urandom_range(sbytes.size() - 1)];
        else sbytes[$urandom_range(sbytes.size() - 1)] = 8'($urandom);
      end else if ($urandom_range(4) == 0) add_byte(8'($urandom));
      sent += sbytes.size();
      send_stream();
    end
  endtask

  task automatic test_backpressure();
    hold_reqs++;
    build_stream(1);
    send_stream();
    wait_drained();
  endtask

  initial begin
    parser_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct_in = 16; idle_pct_out = 69;
    test_header_and_zero_count();
    test_all_types();
    test_backpressure();
    idle_pct_in = 69; idle_pct_out = 16;
    test_bad_tags_and_early_end();
    idle_pct_in = 0; idle_pct_out = 0;
    test_random_streams(20);
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
